/* hw/rtl/owrs_pkg.sv */
// ----------------------------------------------------------------------------
// owrs_pkg
// Shared widths, constants and status codes of the 1-wire ROM search step core.
// ----------------------------------------------------------------------------
`default_nettype none

package owrs_pkg;

  // number of ROM ID bits walked per device
  localparam int unsigned IdBits   = 64;
  localparam int unsigned IdW      = 64;
  localparam int unsigned PosW     = 6;
  localparam int unsigned BitNumW  = 7;
  localparam int unsigned CountW   = 8;
  localparam int unsigned StatusW  = 3;

  localparam logic [CountW-1:0] MaxDevicesRst = 8'hFF;

  typedef enum logic [StatusW-1:0] {
    StBitTaken  = 3'd0,
    StIdMore    = 3'd1,
    StIdLast    = 3'd2,
    StNoResp    = 3'd3,
    StIdle      = 3'd4
  } status_e;

  typedef enum logic {
    OpStart = 1'b0,
    OpPair  = 1'b1
  } op_e;

endpackage : owrs_pkg

`default_nettype wire

/* hw/rtl/onewire_rom_search_step_core.sv */
// ----------------------------------------------------------------------------
// onewire_rom_search_step_core
// Decision core of the 1-wire ROM search: one read-slot bit pair in, one
// direction bit and search status out.
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after the transaction is accepted
// throughput: 1 transaction per cycle while results are taken; the search state
//   updates in the accept cycle and the result register frees itself when the result is taken
// reset: search idle, max_devices = 255, all search state cleared
// ----------------------------------------------------------------------------
`default_nettype none

module onewire_rom_search_step_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [owrs_pkg::CountW-1:0]   cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          op_i,
  input  wire logic                          id_bit_i,
  input  wire logic                          complement_bit_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               write_bit_o,
  output logic [owrs_pkg::StatusW-1:0]       status_o,
  output logic [owrs_pkg::IdW-1:0]           device_id_o,
  output logic [owrs_pkg::CountW-1:0]        device_count_o
);
  import owrs_pkg::*;

  logic [CountW-1:0]  max_dev_q;
  logic [BitNumW-1:0] bit_num_q, bit_num_d;
  logic [IdW-1:0]     cur_id_q, cur_id_d;
  logic [IdW-1:0]     prev_id_q, prev_id_d;
  logic [BitNumW-1:0] last_disc_q, last_disc_d;
  logic [BitNumW-1:0] new_disc_q, new_disc_d;
  logic [CountW-1:0]  found_q, found_d;
  logic               active_q, active_d;

  logic               out_valid_q;
  logic               wbit_q, wbit_d;
  status_e            status_q, status_d;
  logic [IdW-1:0]     dev_q, dev_d;

  logic               accept;
  logic [PosW-1:0]    pos;
  logic [IdW-1:0]     id_with_bit;
  logic [BitNumW-1:0] nd_pair;
  logic               sel;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pos = PosW'(bit_num_q - BitNumW'(1));

  always_comb begin
    sel     = 1'b0;
    nd_pair = new_disc_q;
    if (id_bit_i) begin
      sel = 1'b1;
    end else if (complement_bit_i) begin
      sel = 1'b0;
    end else if (bit_num_q < last_disc_q) begin
      // follow the previous ID below the last discrepancy
      sel = prev_id_q[pos];
      if (sel) begin
        nd_pair = bit_num_q;
      end
    end else if (bit_num_q == last_disc_q) begin
      sel = 1'b0;
    end else begin
      // new branch: this variant takes 1 first
      sel     = 1'b1;
      nd_pair = bit_num_q;
    end
  end

  always_comb begin
    id_with_bit      = cur_id_q;
    id_with_bit[pos] = sel;
  end

  always_comb begin
    bit_num_d   = bit_num_q;
    cur_id_d    = cur_id_q;
    prev_id_d   = prev_id_q;
    last_disc_d = last_disc_q;
    new_disc_d  = new_disc_q;
    found_d     = found_q;
    active_d    = active_q;
    wbit_d      = 1'b0;
    status_d    = StIdle;
    dev_d       = '0;

    if (op_i == OpStart) begin
      bit_num_d   = BitNumW'(1);
      cur_id_d    = '0;
      prev_id_d   = '0;
      last_disc_d = '0;
      new_disc_d  = '0;
      found_d     = '0;
      active_d    = (max_dev_q != '0);
    end else if (active_q) begin
      if (id_bit_i && complement_bit_i) begin
        status_d = StNoResp;
        active_d = 1'b0;
      end else begin
        wbit_d = sel;
        if (bit_num_q >= BitNumW'(IdBits)) begin
          found_d   = found_q + CountW'(1);
          prev_id_d = id_with_bit;
          dev_d     = id_with_bit;
          if (nd_pair == '0 || found_d >= max_dev_q) begin
            status_d = StIdLast;
            active_d = 1'b0;
          end else begin
            status_d    = StIdMore;
            last_disc_d = nd_pair;
          end
          new_disc_d = '0;
          bit_num_d  = BitNumW'(1);
          cur_id_d   = '0;
        end else begin
          status_d   = StBitTaken;
          cur_id_d   = id_with_bit;
          new_disc_d = nd_pair;
          bit_num_d  = bit_num_q + BitNumW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dev_q   <= MaxDevicesRst;
      bit_num_q   <= BitNumW'(1);
      cur_id_q    <= '0;
      prev_id_q   <= '0;
      last_disc_q <= '0;
      new_disc_q  <= '0;
      found_q     <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_dev_q <= cfg_wdata_i;
      end
      if (accept) begin
        bit_num_q   <= bit_num_d;
        cur_id_q    <= cur_id_d;
        prev_id_q   <= prev_id_d;
        last_disc_q <= last_disc_d;
        new_disc_q  <= new_disc_d;
        found_q     <= found_d;
        active_q    <= active_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wbit_q   <= wbit_d;
      status_q <= status_d;
      dev_q    <= dev_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_bit_o    = wbit_q;
  assign status_o       = status_q;
  assign device_id_o    = dev_q;
  assign device_count_o = found_q;

  // an accepted transaction always shows a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("result missing after accepted transaction");

  // an ID is only reported together with a completion status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StIdMore && status_o != StIdLast |-> device_id_o == '0)
    else $error("device id present without completion status");

  // a direction bit of 1 only comes from a taken bit or a completed ID
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_bit_o |->
      (status_o == StBitTaken || status_o == StIdMore || status_o == StIdLast))
    else $error("write bit set with idle or no-response status");

  // bit position stays within the ID
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_num_q != '0 && bit_num_q <= BitNumW'(IdBits))
    else $error("bit number out of range");

endmodule : onewire_rom_search_step_core

`default_nettype wire

/* sim/tb_onewire_rom_search_step_core.sv */
// ----------------------------------------------------------------------------
// tb_onewire_rom_search_step_core
// Self-checking bench for the 1-wire ROM search step core. A small bus model
// of virtual devices answers the read slots from the direction bits the core
// is predicted to write. Full enumerations, corrupted slots, restarts and
// device limits are run under several sender/receiver throttling mixes. Each
// result is checked field by field against an in-bench search predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_onewire_rom_search_step_core;
  timeunit 1ns;
  timeprecision 1ps;

  import owrs_pkg::*;

  typedef struct packed {
    logic                write_bit;
    status_e             status;
    logic [IdW-1:0]      dev_id;
    logic [CountW-1:0]   count;
  } step_result_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic [CountW-1:0]   cfg_wdata_i      = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic                op_i             = 1'b0;
  logic                id_bit_i         = 1'b0;
  logic                complement_bit_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic                write_bit_o;
  logic [StatusW-1:0]  status_o;
  logic [IdW-1:0]      device_id_o;
  logic [CountW-1:0]   device_count_o;

  // predictor state
  logic [CountW-1:0]   cfg_max = MaxDevicesRst;
  logic [BitNumW-1:0]  srch_bitnum = 7'd1;
  logic [IdW-1:0]      srch_cur = '0;
  logic [IdW-1:0]      srch_prev = '0;
  logic [BitNumW-1:0]  srch_last_disc = '0;
  logic [BitNumW-1:0]  srch_new_disc = '0;
  logic [CountW-1:0]   srch_found = '0;
  logic                srch_on = 1'b0;

  // virtual devices on the bus
  logic [IdW-1:0]      bus_rom [8];
  int                  bus_n = 0;
  logic [7:0]          bus_alive = '0;

  step_result_t        expected_results [$];
  step_result_t        last_result;
  int                  idle_pct = 0;
  int                  stall_pct = 0;
  int                  mismatches = 0;
  int                  items_sent = 0;
  int                  results_checked = 0;
  int                  ids_completed = 0;
  int                  enumerations = 0;

  onewire_rom_search_step_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .id_bit_i         (id_bit_i),
    .complement_bit_i (complement_bit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .write_bit_o      (write_bit_o),
    .status_o         (status_o),
    .device_id_o      (device_id_o),
    .device_count_o   (device_count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #1_600_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  function automatic step_result_t search_predict(op_e op, logic idb, logic cmp);
    step_result_t r;
    logic [PosW-1:0] pos;
    logic sel;
    r = '{write_bit: 1'b0, status: StIdle, dev_id: '0, count: '0};
    if (op == OpStart) begin
      srch_bitnum = 7'd1;
      srch_cur = '0;
      srch_prev = '0;
      srch_last_disc = '0;
      srch_new_disc = '0;
      srch_found = '0;
      srch_on = (cfg_max != 0);
    end else if (srch_on) begin
      if (idb && cmp) begin
        r.status = StNoResp;
        srch_on = 1'b0;
      end else begin
        pos = PosW'(srch_bitnum - 7'd1);
        if (idb) begin
          sel = 1'b1;
        end else if (cmp) begin
          sel = 1'b0;
        end else if (srch_bitnum < srch_last_disc) begin
          // below the last discrepancy: retrace the previous ID
          sel = srch_prev[pos];
          if (sel) srch_new_disc = srch_bitnum;
        end else if (srch_bitnum == srch_last_disc) begin
          sel = 1'b0;
        end else begin
          // fresh branch: this variant takes 1 first
          sel = 1'b1;
          srch_new_disc = srch_bitnum;
        end
        srch_cur[pos] = sel;
        r.write_bit = sel;
        if (srch_bitnum >= IdBits) begin
          srch_found = srch_found + 8'd1;
          srch_prev = srch_cur & ((IdBits >= 64) ? {IdW{1'b1}} : ((64'd1 << IdBits) - 64'd1));
          r.dev_id = srch_prev;
          if (srch_new_disc == 0 || srch_found >= cfg_max) begin
            r.status = StIdLast;
            srch_on = 1'b0;
          end else begin
            r.status = StIdMore;
            srch_last_disc = srch_new_disc;
          end
          srch_new_disc = '0;
          srch_bitnum = 7'd1;
          srch_cur = '0;
        end else begin
          r.status = StBitTaken;
          srch_bitnum = srch_bitnum + 7'd1;
        end
      end
    end
    r.count = srch_found;
    return r;
  endfunction

  // wired-AND of the id bit and its complement over the devices still in play
  function automatic void bus_pair(output logic idb, output logic cmp);
    logic [PosW-1:0] pos;
    pos = PosW'(srch_bitnum - 7'd1);
    idb = 1'b1;
    cmp = 1'b1;
    for (int i = 0; i < bus_n; i++) begin
      if (bus_alive[i]) begin
        idb &= bus_rom[i][pos];
        cmp &= ~bus_rom[i][pos];
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [IdW-1:0] got, logic [IdW-1:0] want);
    $display("%0t ns: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : result_check
    step_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction, status", IdW'(status_o), '0);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (write_bit_o !== want.write_bit)
          report_mismatch("write_bit", IdW'(write_bit_o), IdW'(want.write_bit));
        if (status_o !== want.status)
          report_mismatch("status", IdW'(status_o), IdW'(want.status));
        if (device_id_o !== want.dev_id)
          report_mismatch("device_id", device_id_o, want.dev_id);
        if (device_count_o !== want.count)
          report_mismatch("device_count", IdW'(device_count_o), IdW'(want.count));
      end
    end
  end

  task automatic send_item(op_e op, logic idb, logic cmp);
    logic [PosW-1:0] pos;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    id_bit_i         <= idb;
    complement_bit_i <= cmp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pos = PosW'(srch_bitnum - 7'd1);
    last_result = search_predict(op, idb, cmp);
    expected_results.push_back(last_result);
    items_sent++;
    if (last_result.status == StBitTaken) begin
      for (int i = 0; i < bus_n; i++)
        if (bus_rom[i][pos] != last_result.write_bit) bus_alive[i] = 1'b0;
    end else begin
      bus_alive = 8'((1 << bus_n) - 1);
    end
    if (last_result.status inside {StIdMore, StIdLast}) ids_completed++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_max_devices(logic [CountW-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_max = val;
  endtask

  // one full search over a fresh random device set; lower_at > 0 drops the
  // device limit to 1 once that many IDs are found
  task automatic run_enumeration(int n_devs, bit noisy, int lower_at);
    logic [IdW-1:0] base;
    logic idb;
    logic cmp;
    int guard;
    case ($urandom_range(9))
      0: base = '0;
      1: base = '1;
      default: base = {$urandom(), $urandom()};
    endcase
    bus_n = n_devs;
    for (int i = 0; i < n_devs; i++) begin
      bus_rom[i] = base;
      if (i != 0)
        repeat ($urandom_range(1, 3)) bus_rom[i][$urandom_range(IdBits - 1)] ^= 1'b1;
    end
    bus_alive = 8'((1 << bus_n) - 1);
    enumerations++;
    send_item(OpStart, 1'($urandom_range(1)), 1'($urandom_range(1)));
    guard = 0;
    do begin
      bus_pair(idb, cmp);
      if (noisy && $urandom_range(99) < 4) idb = ~idb;
      if (noisy && $urandom_range(99) < 4) cmp = ~cmp;
      if (noisy && $urandom_range(199) == 0)
        send_item(OpStart, idb, cmp);
      else
        send_item(OpPair, idb, cmp);
      if (lower_at != 0 && last_result.status == StIdMore && last_result.count == lower_at)
        set_max_devices(8'd1);
      guard++;
    end while (!(last_result.status inside {StIdLast, StNoResp}) && guard < 600);
  endtask

  task automatic test_directed();
    // pairs before any start are ignored
    send_item(OpPair, 1'b0, 1'b0);
    send_item(OpPair, 1'b0, 1'b1);
    send_item(OpPair, 1'b1, 1'b0);
    send_item(OpPair, 1'b1, 1'b1);
    // nobody on the bus
    send_item(OpStart, 1'b1, 1'b1);
    send_item(OpPair, 1'b1, 1'b1);
    send_item(OpPair, 1'b0, 1'b0);
    // forced bits, then conflicts on fresh branches
    send_item(OpStart, 1'b0, 1'b0);
    send_item(OpPair, 1'b1, 1'b0);
    send_item(OpPair, 1'b0, 1'b1);
    send_item(OpPair, 1'b0, 1'b0);
    send_item(OpPair, 1'b0, 1'b0);
    send_item(OpPair, 1'b1, 1'b0);
    send_item(OpStart, 1'b0, 1'b1);
    send_item(OpPair, 1'b0, 1'b0);
    send_item(OpPair, 1'b1, 1'b1);
    send_item(OpPair, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_enumeration(int target);
    while (items_sent < target) begin
      case ($urandom_range(5))
        0: set_max_devices(8'($urandom_range(1, 4)));
        1: set_max_devices(8'($urandom_range(1, 255)));
        2: set_max_devices(MaxDevicesRst);
        default: ;
      endcase
      run_enumeration($urandom_range(1, 4), ($urandom_range(3) == 0), 0);
    end
    drain();
  endtask

  task automatic test_device_limit();
    set_max_devices(8'd1);
    run_enumeration(4, 1'b0, 0);
    set_max_devices(8'd255);
    run_enumeration(2, 1'b0, 0);
    set_max_devices(8'd255);
    run_enumeration(4, 1'b0, 2);
    drain();
  endtask

  initial begin : main
    int guard;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      test_enumeration(items_sent + 40);
      test_device_limit();
    end
    in_valid_i <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (5) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", IdW'(expected_results.size()), '0);
    $display("%0d bit-pair and start transactions, %0d results checked", items_sent,
             results_checked);
    $display("%0d enumerations run, %0d device IDs completed", enumerations, ids_completed);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* onewire_rom_search_step_core.f */
hw/rtl/owrs_pkg.sv
hw/rtl/onewire_rom_search_step_core.sv
sim/tb_onewire_rom_search_step_core.sv
